// ===== rtl/core/dcnf_pkg.sv =====
package dcnf_pkg;

	localparam int NUMBER_BITS = 31;
	localparam logic [30:0] NUM_MAX = 31'((64'd1 << NUMBER_BITS) - 64'd1);
	localparam logic [30:0] NUM_MAX_DIV10 = 31'(NUM_MAX / 31'd10);
	localparam logic [30:0] MAX_VAR_RESET = 31'd1073741823;

	typedef enum logic [4:0] {
		PH_LEAD         = 5'd0,
		PH_LEAD_COMMENT = 5'd1,
		PH_MATCH        = 5'd2,
		PH_VARS0        = 5'd3,
		PH_VARS1        = 5'd4,
		PH_VARS2        = 5'd5,
		PH_CLS0         = 5'd6,
		PH_CLS1         = 5'd7,
		PH_CLS2         = 5'd8,
		PH_IMP0         = 5'd9,
		PH_IMP1         = 5'd10,
		PH_IMP2         = 5'd11,
		PH_LIT0         = 5'd12,
		PH_LIT1         = 5'd13,
		PH_LIT2         = 5'd14,
		PH_HDR_TAIL     = 5'd15,
		PH_BODY         = 5'd16,
		PH_BODY_COMMENT = 5'd17
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_LITERAL = 2'd1,
		KIND_DONE    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	localparam logic [4:0] ERR_CR = 5'd0;
	localparam logic [4:0] ERR_EOF_COMMENT = 5'd1;
	localparam logic [4:0] ERR_HDR_AFTER_CMT = 5'd2;
	localparam logic [4:0] ERR_EMPTY = 5'd3;
	localparam logic [4:0] ERR_HDR_OR_CMT = 5'd4;
	localparam logic [4:0] ERR_BAD_HDR = 5'd5;
	localparam logic [4:0] ERR_BAD_VARS = 5'd6;
	localparam logic [4:0] ERR_NO_SPACE_VARS = 5'd7;
	localparam logic [4:0] ERR_TOO_MANY_VARS = 5'd8;
	localparam logic [4:0] ERR_BAD_CLS = 5'd9;
	localparam logic [4:0] ERR_EOF_HDR = 5'd10;
	localparam logic [4:0] ERR_BAD_AFTER_HDR = 5'd11;
	localparam logic [4:0] ERR_LIT_OR_CMT = 5'd12;
	localparam logic [4:0] ERR_BAD_LIT = 5'd13;
	localparam logic [4:0] ERR_NO_WS_LIT = 5'd14;
	localparam logic [4:0] ERR_NO_CLAUSE = 5'd15;
	localparam logic [4:0] ERR_MULTI_CLAUSE = 5'd16;
	localparam logic [4:0] ERR_TOO_MANY_CLS = 5'd17;
	localparam logic [4:0] ERR_ZERO_MISSING = 5'd18;
	localparam logic [4:0] ERR_CLS_MISSING = 5'd19;

	// one result record
	typedef struct packed {
		kind_t       kind;
		logic [31:0] literal;
		logic [30:0] variable_count;
		logic [30:0] clause_count;
		logic [30:0] important_count;
		logic        projected;
		logic [4:0]  error_code;
		logic [31:0] line_number;
	} result_t;

	// character after carriage return folding
	typedef struct packed {
		logic       is_eof;
		logic       is_cr;
		logic [7:0] ch;
	} char_t;

	function automatic logic [7:0] pattern_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h20;
			3'd1: c = 8'h63;
			3'd2: c = 8'h6e;
			3'd3: c = 8'h66;
			3'd4: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/dimacs_cnf_stream_parser.sv =====
// DIMACS CNF byte stream parser. One byte (or the end-of-input mark) is
// taken per cycle and at most one result is produced per item: the parsed
// header, each literal, a final clause count, or an error with its line
// number, after which the block ignores input until reset. The input is
// registered once, the parse step runs in the next cycle and its result
// lands in a two-entry output buffer. Input flows at one item per cycle as
// long as results are taken as they appear; it stalls when the results waiting,
// plus one for an item in the parse stage, less one for a result leaving that
// cycle, reach two.
module dimacs_cnf_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic signed [31:0] literal,
	output logic [30:0] variable_count,
	output logic [30:0] clause_count,
	output logic [30:0] important_count,
	output logic        projected,
	output logic [4:0]  error_code,
	output logic [31:0] line_number,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);

	logic [30:0] max_var_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	logic        res_valid;
	dcnf_pkg::result_t res;
	logic        step;
	dcnf_pkg::result_t buf_q [2];
	logic [1:0]  cnt_q;
	logic        rd_q;
	logic        pop;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_var_q <= dcnf_pkg::MAX_VAR_RESET;
		else if (cfg_valid) max_var_q <= cfg_data;
	end

	// stall when the buffer could overflow with the stage in flight
	assign in_stall = (cnt_q + {1'b0, v_s1} - {1'b0, pop}) >= 2'd2;
	assign step = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid && !in_stall;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eoi_s1 <= end_of_input;
		end
	end

	dcnf_parse u_parse (
		.clk(clk), .arst_n(arst_n), .step(step), .data_byte(byte_s1),
		.end_of_input(eoi_s1), .max_var(max_var_q), .res_valid(res_valid), .res(res)
	);

	// two-entry result fifo
	assign pop = out_valid && !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, res_valid} - {1'b0, pop};
			if (pop) rd_q <= ~rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) buf_q[rd_q ^ cnt_q[0]] <= res;
	end

	assign out_valid = cnt_q != 2'd0;
	assign kind = buf_q[rd_q].kind;
	assign literal = buf_q[rd_q].literal;
	assign variable_count = buf_q[rd_q].variable_count;
	assign clause_count = buf_q[rd_q].clause_count;
	assign important_count = buf_q[rd_q].important_count;
	assign projected = buf_q[rd_q].projected;
	assign error_code = buf_q[rd_q].error_code;
	assign line_number = buf_q[rd_q].line_number;

endmodule

// ===== rtl/core/dcnf_parse.sv =====
module dcnf_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_input,
	input  logic [30:0]            max_var,
	output logic                   res_valid,
	output dcnf_pkg::result_t      res
);

	dcnf_pkg::phase_t phase_q, phase_d;
	logic [2:0]  match_q, match_d;
	logic [30:0] acc_q, acc_d;
	logic        neg_q, neg_d;
	logic [31:0] line_q, line_d;
	logic [31:0] lit_line_q, lit_line_d;
	logic        prev_nl_q, prev_nl_d;
	logic        cr_pend_q, cr_pend_d;
	logic        cmt_seen_q, cmt_seen_d;
	logic [30:0] hvars_q, hvars_d;
	logic [30:0] hcls_q, hcls_d;
	logic [30:0] parsed_q, parsed_d;
	logic        last_nz_q, last_nz_d;
	logic        stopped_q, stopped_d;
	logic [30:0] imp_q, imp_d;
	logic        proj_q, proj_d;

	dcnf_pkg::char_t c;
	logic        have_ch;
	logic        emit;
	dcnf_pkg::result_t r;

	// number feed helpers
	logic        is_dig;
	logic [30:0] dval;
	logic [34:0] acc10;
	logic [34:0] acc_next;
	logic        ovf;
	logic [1:0]  nstage;
	logic [1:0]  nres;
	logic        is_blank;
	logic        is_nl;
	logic [30:0] num_fin;
	logic        neg_fin;

	always_comb begin
		c = '0;
		have_ch = 1'b0;
		cr_pend_d = cr_pend_q;
		if (cr_pend_q) begin
			cr_pend_d = 1'b0;
			have_ch = 1'b1;
			if (!end_of_input && data_byte == 8'h0a) c.ch = 8'h0a;
			else c.is_cr = 1'b1;
		end else if (end_of_input) begin
			have_ch = 1'b1;
			c.is_eof = 1'b1;
		end else if (data_byte == 8'h0d) begin
			cr_pend_d = 1'b1;
		end else begin
			have_ch = 1'b1;
			c.ch = data_byte;
		end
	end

	// per-character state update
	always_comb begin
		phase_d = phase_q; match_d = match_q; acc_d = acc_q; neg_d = neg_q;
		line_d = line_q; lit_line_d = lit_line_q; prev_nl_d = prev_nl_q;
		cmt_seen_d = cmt_seen_q; hvars_d = hvars_q; hcls_d = hcls_q;
		parsed_d = parsed_q; last_nz_d = last_nz_q; stopped_d = stopped_q;
		imp_d = imp_q; proj_d = proj_q;
		emit = 1'b0;
		r = '0;
		r.kind = dcnf_pkg::KIND_ERROR;
		is_nl = !c.is_eof && !c.is_cr && c.ch == 8'h0a;
		is_blank = !c.is_eof && !c.is_cr && (c.ch == 8'h20 || c.ch == 8'h09);
		is_dig = !c.is_eof && !c.is_cr && c.ch >= 8'h30 && c.ch <= 8'h39;
		dval = 31'(c.ch - 8'h30);
		acc10 = {4'd0, acc_q} * 35'd10;
		acc_next = acc10 + {4'd0, dval};
		ovf = (acc_q > dcnf_pkg::NUM_MAX_DIV10) || (acc_next > {4'd0, dcnf_pkg::NUM_MAX});
		nstage = 2'd0; nres = 2'd0;
		num_fin = acc_q; neg_fin = neg_q;

		if (have_ch) begin
			if (prev_nl_q && line_q != 32'hffffffff) line_d = line_q + 32'd1;
			prev_nl_d = is_nl;
			unique case (phase_q)
				dcnf_pkg::PH_LEAD: begin
					if (!c.is_eof && !c.is_cr && c.ch == 8'h63) begin
						cmt_seen_d = 1'b1;
						phase_d = dcnf_pkg::PH_LEAD_COMMENT;
					end else if (c.is_eof) begin
						emit = 1'b1;
						if (cmt_seen_q) begin
							r.error_code = dcnf_pkg::ERR_HDR_AFTER_CMT;
							r.line_number = (line_d != 32'd0) ? line_d - 32'd1 : 32'd0;
						end else begin
							r.error_code = dcnf_pkg::ERR_EMPTY;
							r.line_number = line_d;
						end
					end else if (c.is_cr || c.ch != 8'h70) begin
						emit = 1'b1;
						r.error_code = dcnf_pkg::ERR_HDR_OR_CMT;
						r.line_number = line_d;
					end else begin
						phase_d = dcnf_pkg::PH_MATCH;
						match_d = 3'd0;
					end
				end
				dcnf_pkg::PH_LEAD_COMMENT, dcnf_pkg::PH_BODY_COMMENT: begin
					if (is_nl) begin
						phase_d = (phase_q == dcnf_pkg::PH_LEAD_COMMENT) ?
							dcnf_pkg::PH_LEAD : dcnf_pkg::PH_BODY;
					end else if (c.is_cr) begin
						emit = 1'b1; r.error_code = dcnf_pkg::ERR_CR; r.line_number = line_d;
					end else if (c.is_eof) begin
						emit = 1'b1; r.error_code = dcnf_pkg::ERR_EOF_COMMENT;
						r.line_number = line_d;
					end
				end
				dcnf_pkg::PH_MATCH: begin
					if (match_q >= 3'd5 || c.is_eof || c.is_cr ||
							c.ch != dcnf_pkg::pattern_char(match_q)) begin
						emit = 1'b1; r.error_code = dcnf_pkg::ERR_BAD_HDR; r.line_number = line_d;
					end else begin
						match_d = match_q + 3'd1;
						if (match_q == 3'd4) phase_d = dcnf_pkg::PH_VARS0;
					end
				end
				dcnf_pkg::PH_HDR_TAIL: ;
				dcnf_pkg::PH_BODY: begin
					if (!c.is_eof && !c.is_cr && c.ch == 8'h63) begin
						phase_d = dcnf_pkg::PH_BODY_COMMENT;
					end else if (c.is_cr) begin
						emit = 1'b1; r.error_code = dcnf_pkg::ERR_CR; r.line_number = line_d;
					end else if (is_blank || is_nl) begin
					end else if (c.is_eof) begin
						emit = 1'b1;
						if (last_nz_q) begin
							r.error_code = dcnf_pkg::ERR_ZERO_MISSING;
							r.line_number = lit_line_q;
						end else if (parsed_q != hcls_q) begin
							r.error_code = dcnf_pkg::ERR_CLS_MISSING;
							r.line_number = line_d;
						end else begin
							r.kind = dcnf_pkg::KIND_DONE;
							r.variable_count = hvars_q;
							r.clause_count = parsed_q;
						end
					end else if (c.ch != 8'h2d && !is_dig) begin
						emit = 1'b1; r.error_code = dcnf_pkg::ERR_LIT_OR_CMT;
						r.line_number = line_d;
					end
				end
				default: ;
			endcase

			// number tokeniser for header numbers and literals
			if ((phase_q >= dcnf_pkg::PH_VARS0 && phase_q <= dcnf_pkg::PH_LIT2) ||
					(phase_q == dcnf_pkg::PH_BODY && (is_dig ||
					(!c.is_eof && !c.is_cr && c.ch == 8'h2d)))) begin
				logic [4:0] ph;
				logic [4:0] base;
				ph = (phase_q == dcnf_pkg::PH_BODY) ? 5'(dcnf_pkg::PH_LIT0) : 5'(phase_q);
				if (ph <= 5'd5) begin nstage = 2'(ph - 5'd3); base = 5'd3; end
				else if (ph <= 5'd8) begin nstage = 2'(ph - 5'd6); base = 5'd6; end
				else if (ph <= 5'd11) begin nstage = 2'(ph - 5'd9); base = 5'd9; end
				else begin nstage = 2'(ph - 5'd12); base = 5'd12; end
				case (nstage)
					2'd0: begin
						lit_line_d = line_d;
						if (!c.is_eof && !c.is_cr && c.ch == 8'h2d) begin
							neg_d = 1'b1; phase_d = dcnf_pkg::phase_t'(base + 5'd1);
						end else if (!is_dig) nres = 2'd2;
						else begin
							neg_d = 1'b0; acc_d = dval;
							phase_d = dcnf_pkg::phase_t'(base + 5'd2);
						end
					end
					2'd1: begin
						if (!is_dig || c.ch == 8'h30) nres = 2'd2;
						else begin acc_d = dval; phase_d = dcnf_pkg::phase_t'(base + 5'd2); end
					end
					default: begin
						if (!is_dig) nres = 2'd1;
						else if (ovf) nres = 2'd2;
						else acc_d = acc_next[30:0];
					end
				endcase
				num_fin = acc_q; neg_fin = neg_d;
				if (nres != 2'd0) begin
					if (base == 5'd3) begin
						emit = 1'b1; r.line_number = line_d;
						if (nres == 2'd2 || neg_fin) r.error_code = dcnf_pkg::ERR_BAD_VARS;
						else if (!(!c.is_eof && !c.is_cr && c.ch == 8'h20))
							r.error_code = dcnf_pkg::ERR_NO_SPACE_VARS;
						else if (num_fin > max_var) r.error_code = dcnf_pkg::ERR_TOO_MANY_VARS;
						else begin
							emit = 1'b0; hvars_d = num_fin; phase_d = dcnf_pkg::PH_CLS0;
						end
					end else if (base == 5'd6 || base == 5'd9) begin
						if (base == 5'd6 && (nres == 2'd2 || neg_fin)) begin
							emit = 1'b1; r.line_number = line_d;
							r.error_code = dcnf_pkg::ERR_BAD_CLS;
						end else begin
							if (base == 5'd6) hcls_d = num_fin;
							if (base == 5'd9 && nres == 2'd1 && !neg_fin && num_fin <= hvars_q) begin
								proj_d = 1'b1; imp_d = num_fin;
							end
							if (base == 5'd6 && !c.is_eof && !c.is_cr && c.ch == 8'h20)
								phase_d = dcnf_pkg::PH_IMP0;
							else phase_d = dcnf_pkg::PH_HDR_TAIL;
						end
					end else begin
						emit = 1'b1;
						if (nres == 2'd2) begin
							r.error_code = dcnf_pkg::ERR_BAD_LIT; r.line_number = lit_line_d;
						end else if (!(is_blank || is_nl || (!c.is_eof && !c.is_cr &&
								c.ch == 8'h63))) begin
							r.error_code = dcnf_pkg::ERR_NO_WS_LIT; r.line_number = line_d;
						end else if (hcls_q == 31'd0) begin
							r.error_code = dcnf_pkg::ERR_NO_CLAUSE; r.line_number = line_d;
						end else if (parsed_q == 31'd1 && hcls_q == 31'd1) begin
							r.error_code = dcnf_pkg::ERR_MULTI_CLAUSE; r.line_number = line_d;
						end else if (parsed_q == hcls_q) begin
							r.error_code = dcnf_pkg::ERR_TOO_MANY_CLS; r.line_number = line_d;
						end else if (num_fin > hvars_q) begin
							r.error_code = dcnf_pkg::ERR_BAD_LIT; r.line_number = lit_line_d;
						end else begin
							if (num_fin == 31'd0) parsed_d = parsed_q + 31'd1;
							last_nz_d = (num_fin != 31'd0);
							phase_d = (c.ch == 8'h63) ? dcnf_pkg::PH_BODY_COMMENT :
								dcnf_pkg::PH_BODY;
							r.kind = dcnf_pkg::KIND_LITERAL;
							r.literal = neg_fin ? 32'd0 - {1'b0, num_fin} : {1'b0, num_fin};
						end
					end
				end
			end

			// header line tail, also entered straight after a number
			if ((phase_q == dcnf_pkg::PH_HDR_TAIL) ||
					(phase_d == dcnf_pkg::PH_HDR_TAIL && !emit)) begin
				if (is_nl) begin
					emit = 1'b1; phase_d = dcnf_pkg::PH_BODY;
					r.kind = dcnf_pkg::KIND_HEADER;
					r.variable_count = hvars_d;
					r.clause_count = hcls_d;
					r.projected = proj_d;
					r.important_count = proj_d ? imp_d : 31'd0;
				end else if (is_blank) begin
					phase_d = dcnf_pkg::PH_HDR_TAIL;
				end else begin
					emit = 1'b1; r.line_number = line_d;
					if (c.is_eof) r.error_code = dcnf_pkg::ERR_EOF_HDR;
					else if (c.is_cr) r.error_code = dcnf_pkg::ERR_CR;
					else r.error_code = dcnf_pkg::ERR_BAD_AFTER_HDR;
				end
			end

			if (emit && r.kind == dcnf_pkg::KIND_ERROR) stopped_d = 1'b1;
			if (r.kind == dcnf_pkg::KIND_DONE && emit) stopped_d = 1'b1;
		end
		if (emit && r.kind == dcnf_pkg::KIND_ERROR) begin
			r.literal = '0;
		end
	end

	// kind defaults to error when nothing else is set
	always_comb begin
		res = r;
		res_valid = step && !stopped_q && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dcnf_pkg::PH_LEAD; match_q <= '0; acc_q <= '0; neg_q <= 1'b0;
			line_q <= '0; lit_line_q <= '0; prev_nl_q <= 1'b1; cr_pend_q <= 1'b0;
			cmt_seen_q <= 1'b0; hvars_q <= '0; hcls_q <= '0; parsed_q <= '0;
			last_nz_q <= 1'b0; stopped_q <= 1'b0; imp_q <= '0; proj_q <= 1'b0;
		end else if (step && !stopped_q) begin
			phase_q <= phase_d; match_q <= match_d; acc_q <= acc_d; neg_q <= neg_d;
			line_q <= line_d; lit_line_q <= lit_line_d; prev_nl_q <= prev_nl_d;
			cr_pend_q <= cr_pend_d; cmt_seen_q <= cmt_seen_d; hvars_q <= hvars_d;
			hcls_q <= hcls_d; parsed_q <= parsed_d; last_nz_q <= last_nz_d;
			stopped_q <= stopped_d; imp_q <= imp_d; proj_q <= proj_d;
		end
	end

endmodule
